FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files of the project.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// An implication that is checked in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/scu_pkg.sv
// Shared types, opcodes and field positions of the small processor block.
// No dependencies; every other file but assert_macros.svh imports this package.
package scu_pkg;

    localparam int ADDR_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int PC_OUT_BITS = 16;
    localparam int REG_BITS = 3;

    // Instruction word field positions.
    localparam int OPC_LSB = 25;
    localparam int DST_LSB = 22;
    localparam int SRC0_LSB = 19;
    localparam int SRC1_LSB = 16;
    localparam int IMM_BITS = 16;

    localparam logic [REG_BITS-1:0] REG_IMM  = 3'd1;
    localparam logic [REG_BITS-1:0] REG_LINK = 3'd7;

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [WORD_BITS-1:0] word_t;

    // Item operations.
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_EXEC = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } item_op_t;

    typedef enum logic [6:0] {
        OPC_ADD = 7'd0,
        OPC_SUB = 7'd1,
        OPC_LSF = 7'd2,
        OPC_RSF = 7'd3,
        OPC_AND = 7'd4,
        OPC_OR  = 7'd5,
        OPC_XOR = 7'd6,
        OPC_LHI = 7'd7,
        OPC_LD  = 7'd8,
        OPC_ST  = 7'd9,
        OPC_JLT = 7'd16,
        OPC_JLE = 7'd17,
        OPC_JEQ = 7'd18,
        OPC_JNE = 7'd19,
        OPC_JIN = 7'd20,
        OPC_HLT = 7'd24
    } opcode_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] address;
        logic [31:0] load_word;
    } in_item_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [31:0] value;
        logic [2:0]  dest_index;
        logic        reg_written;
        logic        halted;
        logic        bad_opcode;
    } out_item_t;

    // Requests to the instruction and data stores.
    typedef struct packed {
        logic  we_both;
        logic  we_data;
        logic  re_instr;
        logic  re_data;
        addr_t waddr;
        addr_t raddr;
        word_t wdata;
    } mem_req_t;

    // Requests to the register file.
    typedef struct packed {
        logic                rd_en;
        logic [REG_BITS-1:0] ra_a;
        logic [REG_BITS-1:0] ra_b;
        logic [IMM_BITS-1:0] imm;
        logic                we;
        logic [REG_BITS-1:0] wa;
        word_t               wd;
    } rf_req_t;

    // Outcome of one executed instruction.
    typedef struct packed {
        word_t               value;
        logic [REG_BITS-1:0] dest;
        logic                reg_wr;
        logic                is_ld;
        logic                st_en;
        logic                jump;
        logic                halt;
        logic                bad;
    } exec_res_t;

endpackage

FILE: rtl/scu_mem.sv
// Instruction store and data store, each one synchronous RAM with a registered read.
// Depends on scu_pkg for the request struct and address width.
module scu_mem
    import scu_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output word_t    instr_rdata,
    output word_t    data_rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    word_t instr_mem [DEPTH];
    word_t data_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we_both)
        begin
            instr_mem[req.waddr] <= req.wdata;
        end
        if (req.re_instr)
        begin
            instr_rdata <= instr_mem[req.raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we_both || req.we_data)
        begin
            data_mem[req.waddr] <= req.wdata;
        end
        if (req.re_data)
        begin
            data_rdata <= data_mem[req.raddr];
        end
    end

endmodule

FILE: rtl/scu_regs.sv
// Eight-entry register file with two registered read ports and one write port.
// Depends on scu_pkg. Reads of r1 return the immediate of the current instruction.
module scu_regs
    import scu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  rf_req_t req,
    output word_t   rd_a,
    output word_t   rd_b
);

    localparam int NREGS = 1 << REG_BITS;

    word_t              regs [NREGS];
    logic [NREGS-1:0]   valid_reg;
    word_t              rdata_a_reg;
    word_t              rdata_b_reg;
    logic               fwd_a_reg;
    logic               fwd_b_reg;
    logic [IMM_BITS-1:0] imm_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            regs[req.wa] <= req.wd;
        end
        if (req.rd_en)
        begin
            rdata_a_reg <= valid_reg[req.ra_a] ? regs[req.ra_a] : '0;
            rdata_b_reg <= valid_reg[req.ra_b] ? regs[req.ra_b] : '0;
            imm_reg     <= req.imm;
        end
    end

    // Entries read as zero until first written after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.wa] <= 1'b1;
            end
            if (req.rd_en)
            begin
                fwd_a_reg <= (req.ra_a == REG_IMM);
                fwd_b_reg <= (req.ra_b == REG_IMM);
            end
        end
    end

    assign rd_a = fwd_a_reg ? word_t'(imm_reg) : rdata_a_reg;
    assign rd_b = fwd_b_reg ? word_t'(imm_reg) : rdata_b_reg;

endmodule

FILE: rtl/scu_alu.sv
// Execute unit: arithmetic, logic, shifts, branch compare and opcode decode.
// Depends on scu_pkg for opcodes and the result struct.
module scu_alu
    import scu_pkg::*;
(
    input  word_t     ins,
    input  word_t     a,
    input  word_t     b,
    input  addr_t     pc,
    output exec_res_t res
);

    opcode_t             opc;
    logic [REG_BITS-1:0] dst;
    logic [IMM_BITS-1:0] imm;
    logic                big_shift;
    logic                taken;

    assign opc       = opcode_t'(ins[WORD_BITS-1:OPC_LSB]);
    assign dst       = ins[DST_LSB +: REG_BITS];
    assign imm       = ins[IMM_BITS-1:0];
    assign big_shift = (b[WORD_BITS-1:5] != '0);

    always_comb
    begin
        case (opc)
            OPC_JLT: taken = (a < b);
            OPC_JLE: taken = (a <= b);
            OPC_JEQ: taken = (a == b);
            OPC_JNE: taken = (a != b);
            default: taken = 1'b1;
        endcase
    end

    always_comb
    begin
        res = '0;
        case (opc)
            OPC_ADD, OPC_SUB, OPC_LSF, OPC_RSF, OPC_AND, OPC_OR, OPC_XOR, OPC_LHI:
            begin
                res.reg_wr = 1'b1;
                res.dest   = dst;
                case (opc)
                    OPC_ADD: res.value = a + b;
                    OPC_SUB: res.value = a - b;
                    OPC_LSF: res.value = big_shift ? '0 : (a << b[4:0]);
                    OPC_RSF: res.value = big_shift ? '0 : (a >> b[4:0]);
                    OPC_AND: res.value = a & b;
                    OPC_OR:  res.value = a | b;
                    OPC_XOR: res.value = a ^ b;
                    default: res.value = {imm, a[IMM_BITS-1:0]};
                endcase
            end
            OPC_LD:
            begin
                res.reg_wr = 1'b1;
                res.dest   = dst;
                res.is_ld  = 1'b1;
            end
            OPC_ST:
            begin
                res.st_en = 1'b1;
                res.value = a;
            end
            OPC_JLT, OPC_JLE, OPC_JEQ, OPC_JNE, OPC_JIN:
            begin
                if (taken)
                begin
                    res.jump   = 1'b1;
                    res.reg_wr = 1'b1;
                    res.dest   = REG_LINK;
                    res.value  = word_t'(pc);
                end
            end
            OPC_HLT:
            begin
                res.halt = 1'b1;
            end
            default:
            begin
                res.bad = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/simple_cpu_instruction_step.sv
// Small 8-register, 32-bit processor stepped one item at a time. A load item
// writes one word into both the instruction store and the data store, a read
// item returns one data-store word, and an execute item fetches the word at the
// program counter and runs it, unless the block has halted. Exactly one result
// item leaves for every item taken in. Items are handled one at a time: a load
// or read goes through the store access and a response state, an execute
// through store fetch, register file read and execute, and an LD adds a read
// of the data store. A result waits in an output register, so the next item is
// taken while it is pending; the block only stalls when a second result is
// ready before the first has left. Store entries that were never written read
// back as arbitrary data. Depends on scu_pkg, scu_mem, scu_regs and scu_alu.
module simple_cpu_instruction_step
    import scu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_DECODE,
        S_EXEC,
        S_LDWB
    } state_t;

    state_t    state_reg, state_next;
    in_item_t  item_reg, item_next;
    addr_t     pc_reg, pc_next;
    logic      halt_reg, halt_next;
    word_t     exec_cnt_reg, exec_cnt_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    mem_req_t  mem_req;
    rf_req_t   rf_req;
    word_t     instr_rdata;
    word_t     data_rdata;
    word_t     rd_a;
    word_t     rd_b;
    exec_res_t res;

    logic      in_fire;
    logic      out_free;
    addr_t     pc_inc;
    addr_t     pc_after;
    opcode_t   dec_opc;

    scu_mem u_mem (
        .clk         (clk),
        .req         (mem_req),
        .instr_rdata (instr_rdata),
        .data_rdata  (data_rdata)
    );

    scu_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rf_req),
        .rd_a  (rd_a),
        .rd_b  (rd_b)
    );

    // The fetched word stays in the store read register until the next fetch,
    // so the execute unit sees a stable instruction across stalls.
    scu_alu u_alu (
        .ins (instr_rdata),
        .a   (rd_a),
        .b   (rd_b),
        .pc  (pc_reg),
        .res (res)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;
    assign dec_opc   = opcode_t'(instr_rdata[WORD_BITS-1:OPC_LSB]);
    assign pc_inc    = pc_reg + addr_t'(1);

    // Program counter after an executed instruction: a taken jump goes to the
    // immediate, a halt stays put, everything else advances with wrap.
    always_comb
    begin
        if (res.jump)
        begin
            pc_after = instr_rdata[ADDR_BITS-1:0];
        end
        else if (res.halt)
        begin
            pc_after = pc_reg;
        end
        else
        begin
            pc_after = pc_inc;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        pc_next        = pc_reg;
        halt_next      = halt_reg;
        exec_cnt_next  = exec_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        mem_req        = '0;
        rf_req         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    item_next = in_data;
                    case (item_op_t'(in_data.op))
                        OP_LOAD:
                        begin
                            mem_req.we_both = 1'b1;
                            mem_req.waddr   = in_data.address[ADDR_BITS-1:0];
                            mem_req.wdata   = in_data.load_word;
                            state_next      = S_RESP;
                        end
                        OP_READ:
                        begin
                            mem_req.re_data = 1'b1;
                            mem_req.raddr   = in_data.address[ADDR_BITS-1:0];
                            state_next      = S_RESP;
                        end
                        OP_EXEC:
                        begin
                            if (halt_reg)
                            begin
                                state_next = S_RESP;
                            end
                            else
                            begin
                                mem_req.re_instr = 1'b1;
                                mem_req.raddr    = pc_reg;
                                state_next       = S_DECODE;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // Loads, reads, unused codes and execute while halted.
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_item_next         = '0;
                    out_item_next.next_pc = PC_OUT_BITS'(pc_reg);
                    out_item_next.halted  = halt_reg;
                    case (item_op_t'(item_reg.op))
                        OP_LOAD: out_item_next.value = item_reg.load_word;
                        OP_READ: out_item_next.value = data_rdata;
                        default: out_item_next.value = '0;
                    endcase
                    state_next = S_IDLE;
                end
            end

            // Read the operands and write the immediate into r1. LHI reads its
            // destination on port A to keep the low half.
            S_DECODE:
            begin
                rf_req.rd_en = 1'b1;
                rf_req.ra_a  = (dec_opc == OPC_LHI) ? instr_rdata[DST_LSB +: REG_BITS]
                                                    : instr_rdata[SRC0_LSB +: REG_BITS];
                rf_req.ra_b  = instr_rdata[SRC1_LSB +: REG_BITS];
                rf_req.imm   = instr_rdata[IMM_BITS-1:0];
                rf_req.we    = 1'b1;
                rf_req.wa    = REG_IMM;
                rf_req.wd    = word_t'(instr_rdata[IMM_BITS-1:0]);
                state_next   = S_EXEC;
            end

            S_EXEC:
            begin
                if (res.is_ld)
                begin
                    mem_req.re_data = 1'b1;
                    mem_req.raddr   = rd_b[ADDR_BITS-1:0];
                    state_next      = S_LDWB;
                end
                else if (out_free)
                begin
                    mem_req.we_data = res.st_en;
                    mem_req.waddr   = rd_b[ADDR_BITS-1:0];
                    mem_req.wdata   = rd_a;
                    rf_req.we       = res.reg_wr;
                    rf_req.wa       = res.dest;
                    rf_req.wd       = res.value;
                    pc_next         = pc_after;
                    halt_next       = halt_reg || res.halt;
                    if (!res.bad)
                    begin
                        exec_cnt_next = exec_cnt_reg + word_t'(1);
                    end
                    out_valid_next            = 1'b1;
                    out_item_next.next_pc     = PC_OUT_BITS'(pc_after);
                    out_item_next.value       = res.value;
                    out_item_next.dest_index  = res.dest;
                    out_item_next.reg_written = res.reg_wr;
                    out_item_next.halted      = halt_reg || res.halt;
                    out_item_next.bad_opcode  = res.bad;
                    state_next                = S_IDLE;
                end
            end

            S_LDWB:
            begin
                if (out_free)
                begin
                    rf_req.we                 = 1'b1;
                    rf_req.wa                 = res.dest;
                    rf_req.wd                 = data_rdata;
                    pc_next                   = pc_inc;
                    exec_cnt_next             = exec_cnt_reg + word_t'(1);
                    out_valid_next            = 1'b1;
                    out_item_next.next_pc     = PC_OUT_BITS'(pc_inc);
                    out_item_next.value       = data_rdata;
                    out_item_next.dest_index  = res.dest;
                    out_item_next.reg_written = 1'b1;
                    out_item_next.halted      = halt_reg;
                    out_item_next.bad_opcode  = 1'b0;
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            exec_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            exec_cnt_reg  <= exec_cnt_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

endmodule

FILE: rtl/scu_checker.sv
// Port-level checker for the processor block, bound to the top level.
// Depends on scu_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module scu_checker
    import scu_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    logic       in_fire;
    logic       out_fire;
    logic [1:0] pending_reg;
    logic       seen_halt_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // Items taken in whose result has not left yet, and whether a halt was seen.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            seen_halt_reg <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_fire) - 2'(out_fire);
            if (out_fire && out_data.halted)
            begin
                seen_halt_reg <= 1'b1;
            end
        end
    end

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")
    `ASSERT_IMPLY(a_no_phantom, out_valid, pending_reg != 2'd0, "result item without a pending input item")
    `ASSERT_IMPLY(a_halt_sticky, out_valid && seen_halt_reg, out_data.halted, "halt flag cleared without reset")
    `ASSERT_IMPLY(a_dest_zero, out_valid && !out_data.reg_written, out_data.dest_index == 3'd0, "destination set without a register write")
    `ASSERT_IMPLY(a_bad_quiet, out_valid && out_data.bad_opcode, !out_data.reg_written && out_data.value == '0, "undefined opcode wrote a value")

endmodule

bind simple_cpu_instruction_step scu_checker u_scu_checker (.*);

FILE: tb/scu_step_checker.sv
// Result checker for the small processor block: watches both channels, predicts
// every result item from its own copy of the processor state and compares.
// Depends on scu_pkg for the item types and opcode names.
module scu_step_checker
    import scu_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  in_item_t                     in_data,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  out_item_t                    out_data,
    output int                           fail_count,
    output int                           pending,
    output addr_t                        model_pc,
    output logic                         model_halted,
    output logic [7:0][WORD_BITS-1:0]    model_regs
);
    timeunit 1ns;
    timeprecision 1ps;

    word_t     gpr [8];
    addr_t     pc_q;
    logic      halt_q;
    word_t     istore [addr_t];
    word_t     dstore [addr_t];
    out_item_t expected_q [$];

    assign model_pc = pc_q;
    assign model_halted = halt_q;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            model_regs[i] = gpr[i];
        end
    end

    // Advances the processor state by one input item and returns its result.
    function automatic out_item_t cpu_step(in_item_t it);
        out_item_t   r;
        addr_t       a_idx;
        addr_t       cur;
        word_t       ins;
        word_t       a;
        word_t       b;
        word_t       res;
        logic [6:0]  opc;
        logic [2:0]  dst;
        logic [2:0]  s0;
        logic [2:0]  s1;
        logic [15:0] imm;
        logic        taken;
        r = '0;
        a_idx = addr_t'(it.address);
        case (it.op)
            OP_LOAD:
            begin
                istore[a_idx] = it.load_word;
                dstore[a_idx] = it.load_word;
                r.value = it.load_word;
            end
            OP_READ:
            begin
                r.value = dstore.exists(a_idx) ? dstore[a_idx] : '0;
            end
            OP_EXEC:
            begin
                if (!halt_q)
                begin
                    cur = pc_q;
                    ins = istore.exists(cur) ? istore[cur] : '0;
                    opc = ins[31:OPC_LSB];
                    dst = ins[DST_LSB +: REG_BITS];
                    s0 = ins[SRC0_LSB +: REG_BITS];
                    s1 = ins[SRC1_LSB +: REG_BITS];
                    imm = ins[IMM_BITS-1:0];
                    // The immediate lands in r1 before the operands are read.
                    gpr[REG_IMM] = {16'b0, imm};
                    a = gpr[s0];
                    b = gpr[s1];
                    pc_q = cur + 1'b1;
                    case (opc)
                        OPC_ADD, OPC_SUB, OPC_LSF, OPC_RSF, OPC_AND, OPC_OR, OPC_XOR,
                        OPC_LHI, OPC_LD:
                        begin
                            case (opc)
                                OPC_ADD: res = a + b;
                                OPC_SUB: res = a - b;
                                OPC_LSF: res = (b >= 32) ? '0 : a << b[4:0];
                                OPC_RSF: res = (b >= 32) ? '0 : a >> b[4:0];
                                OPC_AND: res = a & b;
                                OPC_OR:  res = a | b;
                                OPC_XOR: res = a ^ b;
                                OPC_LHI: res = {imm, gpr[dst][15:0]};
                                default:
                                begin
                                    res = dstore.exists(addr_t'(b)) ? dstore[addr_t'(b)] : '0;
                                end
                            endcase
                            gpr[dst] = res;
                            r.value = res;
                            r.dest_index = dst;
                            r.reg_written = 1'b1;
                        end
                        OPC_ST:
                        begin
                            dstore[addr_t'(b)] = a;
                            r.value = a;
                        end
                        OPC_JLT, OPC_JLE, OPC_JEQ, OPC_JNE, OPC_JIN:
                        begin
                            case (opc)
                                OPC_JLT: taken = a < b;
                                OPC_JLE: taken = a <= b;
                                OPC_JEQ: taken = a == b;
                                OPC_JNE: taken = a != b;
                                default: taken = 1'b1;
                            endcase
                            if (taken)
                            begin
                                gpr[REG_LINK] = word_t'(cur);
                                pc_q = addr_t'(imm);
                                r.value = word_t'(cur);
                                r.dest_index = REG_LINK;
                                r.reg_written = 1'b1;
                            end
                        end
                        OPC_HLT:
                        begin
                            pc_q = cur;
                            halt_q = 1'b1;
                        end
                        default:
                        begin
                            r.bad_opcode = 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        r.next_pc = pc_q;
        r.halted = halt_q;
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                gpr[i] = '0;
            end
            pc_q = '0;
            halt_q = 1'b0;
            istore.delete();
            dstore.delete();
            expected_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // A result leaves only after its item has been taken and registered, so the
            // comparison is done before this cycle's item is predicted.
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result item with no expectation waiting: 0x%0h", out_data);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    compare_field("next_pc", 32'(exp_r.next_pc), 32'(out_data.next_pc));
                    compare_field("value", exp_r.value, out_data.value);
                    compare_field("dest_index", 32'(exp_r.dest_index),
                                  32'(out_data.dest_index));
                    compare_field("reg_written", 32'(exp_r.reg_written),
                                  32'(out_data.reg_written));
                    compare_field("halted", 32'(exp_r.halted), 32'(out_data.halted));
                    compare_field("bad_opcode", 32'(exp_r.bad_opcode),
                                  32'(out_data.bad_opcode));
                end
            end
            if (in_valid && in_ready)
            begin
                expected_q.push_back(cpu_step(in_data));
            end
            pending = expected_q.size();
        end
    end

endmodule

FILE: tb/tb_simple_cpu_instruction_step.sv
// Top of the testbench for the small processor block: clock, reset, stimulus
// and the final verdict. Depends on scu_pkg, the block and scu_step_checker.
module tb_simple_cpu_instruction_step
    import scu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // The highest opcode value, which the processor does not define.
    localparam logic [6:0] OPC_TOP_UNDEFINED = 7'h7f;
    // Programs mostly live in a small window so that loops and reuse happen.
    localparam int WINDOW_WORDS = 64;
    localparam int RANDOM_ITEM_GOAL = 840;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    int                        fail_count;
    int                        pending;
    addr_t                     model_pc;
    logic                      model_halted;
    logic [7:0][WORD_BITS-1:0] model_regs;

    // Record of every word loaded, so that no execute ever fetches, and no LD
    // or read ever touches, a store entry that was never written.
    word_t prog [addr_t];
    addr_t loaded_list [$];

    int   n_items;
    int   burst_left;
    logic offering;

    simple_cpu_instruction_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    scu_step_checker cpu_step_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .model_pc     (model_pc),
        .model_halted (model_halted),
        .model_regs   (model_regs)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("** simple_cpu_instruction_step: FAILED **");
        $finish;
    end

    function automatic in_item_t mk_item(item_op_t op, addr_t a, word_t w);
        in_item_t it;
        it.op = op;
        it.address = a;
        it.load_word = w;
        return it;
    endfunction

    function automatic word_t encode(logic [6:0] opc, logic [2:0] dst, logic [2:0] s0,
                                     logic [2:0] s1, logic [15:0] imm);
        return {opc, dst, s0, s1, imm};
    endfunction

    // A random instruction: mostly defined operations, some jumps and a few
    // undefined opcodes. Half of them take the second operand from r1, which
    // holds the immediate, so shift amounts and addresses are often known.
    function automatic word_t random_instr();
        logic [6:0]  opc;
        logic [2:0]  s1;
        logic [15:0] imm;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 62)
        begin
            opc = 7'($urandom_range(int'(OPC_ADD), int'(OPC_ST)));
        end
        else if (sel < 92)
        begin
            opc = 7'($urandom_range(int'(OPC_JLT), int'(OPC_JIN)));
        end
        else
        begin
            // Undefined opcodes only; a halt would freeze the rest of the run.
            do
            begin
                opc = 7'($urandom_range(int'(OPC_ST) + 1, int'(OPC_TOP_UNDEFINED)));
            end
            while ((opc >= OPC_JLT && opc <= OPC_JIN) || opc == OPC_HLT);
        end
        s1 = ($urandom % 2) ? REG_IMM : 3'($urandom);
        imm = ($urandom % 4 == 0) ? 16'($urandom) : 16'($urandom_range(0, WINDOW_WORDS - 1));
        return encode(opc, 3'($urandom), 3'($urandom), s1, imm);
    endfunction

    function automatic word_t random_data();
        case ($urandom % 4)
            0:       return '1;
            1:       return word_t'($urandom_range(0, 63));
            default: return $urandom;
        endcase
    endfunction

    // Offers one item and waits until it is taken. The sender works in bursts:
    // valid stays high from one item to the next inside a burst, and a burst
    // is followed by a random gap, or by none at all.
    task automatic send_item(in_item_t it);
        int gap;
        in_valid <= 1'b1;
        in_data <= it;
        offering = 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        n_items++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic send_load(addr_t a, word_t w);
        if (!prog.exists(a))
        begin
            loaded_list.push_back(a);
        end
        prog[a] = w;
        send_item(mk_item(OP_LOAD, a, w));
    endtask

    // Loads a known instruction at the current program counter and runs it.
    task automatic run_instr(word_t w);
        send_load(model_pc, w);
        send_item(mk_item(OP_EXEC, addr_t'($urandom), $urandom));
    endtask

    // Stops offering items until every expected result has come back.
    task automatic drain();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            @(negedge clk);
        end
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // One execute step of the running program. Before the step the state is
    // made safe: the word at the program counter must exist and must not be a
    // halt, and an LD must find its data word written. Any repair is a load
    // item of its own, which may in turn change the program, so the state is
    // checked again after each one.
    task automatic exec_step();
        addr_t      pc;
        word_t      ins;
        word_t      b;
        logic [6:0] opc;
        forever
        begin
            pc = model_pc;
            if (model_halted)
            begin
                break;
            end
            if (!prog.exists(pc))
            begin
                send_load(pc, random_instr());
                continue;
            end
            ins = prog[pc];
            opc = ins[31:OPC_LSB];
            if (opc == OPC_HLT)
            begin
                send_load(pc, random_instr());
                continue;
            end
            if (opc == OPC_LD)
            begin
                // r1 takes the immediate before the operands are read.
                b = (ins[SRC1_LSB +: REG_BITS] == REG_IMM) ? {16'b0, ins[15:0]}
                                                            : model_regs[ins[SRC1_LSB +: REG_BITS]];
                if (!prog.exists(addr_t'(b)))
                begin
                    send_load(addr_t'(b), random_data());
                    continue;
                end
            end
            break;
        end
        send_item(mk_item(OP_EXEC, addr_t'($urandom), $urandom));
    endtask

    // The receiver runs through phases of random length, each with a stall
    // pattern of its own: always ready, ready about half the time, or ready
    // about a quarter of the time. One phase early in the run holds off for a long
    // stretch while the sender keeps offering, so the block fills up and
    // stops taking items.
    initial
    begin
        int len;
        int mode;
        int phase;
        out_ready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            if (phase == 8)
            begin
                len = 250;
                mode = 3;
            end
            else
            begin
                len = $urandom_range(20, 80);
                mode = $urandom_range(0, 2);
            end
            repeat (len)
            begin
                @(negedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom % 2);
                    2:       out_ready <= ($urandom % 4 == 0);
                    default: out_ready <= 1'b0;
                endcase
            end
            phase++;
        end
    end

    initial
    begin
        int    sel;
        bit    drained_mid;
        addr_t a;
        in_valid = 1'b0;
        in_data = '0;
        offering = 1'b0;
        n_items = 0;
        burst_left = 1;
        drained_mid = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. The register values build up from step to step:
        // r2 ends up all ones, which then drives the carry-out of an add, a
        // shift by 32, a store and load of the extreme word, and a taken jump
        // to the last address. The jump there is not taken, so the program
        // counter wraps to zero, where the all-ones word is an undefined
        // opcode.
        run_instr(encode(OPC_LHI, 3'd2, 3'd0, 3'd0, 16'hffff));
        run_instr(encode(OPC_OR, 3'd2, 3'd2, REG_IMM, 16'hffff));
        run_instr(encode(OPC_ADD, 3'd3, 3'd2, REG_IMM, 16'h0001));
        run_instr(encode(OPC_LSF, 3'd5, 3'd2, REG_IMM, 16'd32));
        run_instr(encode(OPC_RSF, 3'd6, 3'd2, REG_IMM, 16'd31));
        run_instr(encode(OPC_ST, 3'd0, 3'd2, REG_IMM, 16'h0100));
        run_instr(encode(OPC_LD, 3'd4, 3'd0, REG_IMM, 16'h0100));
        run_instr(encode(OPC_JEQ, 3'd0, 3'd2, 3'd4, 16'hffff));
        run_instr(encode(OPC_JLT, 3'd0, 3'd2, 3'd0, 16'h0000));
        run_instr(encode(OPC_TOP_UNDEFINED, 3'd7, 3'd7, 3'd7, 16'hffff));
        send_item(mk_item(OP_READ, 16'h0100, '0));
        send_item(mk_item(OP_NONE, '1, '1));
        drain();

        // Random part: mostly execute steps of a program that grows on
        // demand, mixed with reprogramming, data loads, reads and the unused
        // operation.
        while (n_items < RANDOM_ITEM_GOAL)
        begin
            if (!drained_mid && n_items >= RANDOM_ITEM_GOAL / 2)
            begin
                drain();
                drained_mid = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                exec_step();
            end
            else if (sel < 82)
            begin
                a = ($urandom % 10 == 0) ? addr_t'($urandom)
                                         : addr_t'($urandom_range(0, WINDOW_WORDS - 1));
                send_load(a, random_instr());
            end
            else if (sel < 90)
            begin
                a = ($urandom % 4 == 0) ? addr_t'($urandom)
                                        : addr_t'($urandom_range(0, 2 * WINDOW_WORDS - 1));
                send_load(a, random_data());
            end
            else if (sel < 97)
            begin
                a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
                send_item(mk_item(OP_READ, a, $urandom));
            end
            else
            begin
                send_item(mk_item(OP_NONE, addr_t'($urandom), $urandom));
            end
        end

        // Halt comes last, since it is sticky until reset: after it, execute
        // items change nothing while loads and reads still work.
        drain();
        run_instr(encode(OPC_HLT, 3'd3, 3'd4, 3'd5, 16'h1234));
        send_item(mk_item(OP_EXEC, '0, '0));
        send_item(mk_item(OP_EXEC, '1, '1));
        send_item(mk_item(OP_LOAD, 16'h0020, 32'h5a5a_a5a5));
        send_item(mk_item(OP_READ, 16'h0020, '0));
        send_item(mk_item(OP_NONE, '0, '0));

        // Wait for the last results, then keep watching for anything
        // the block might still send unasked.
        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("** simple_cpu_instruction_step: PASSED **");
        end
        else
        begin
            $display("** simple_cpu_instruction_step: FAILED **");
        end
        $finish;
    end

endmodule
